[rtl/dmrd_pkg.sv]
// ---------------------------------------------------------------------------
// dmrd_pkg: shared types and constants for the density map deposit unit
// operation codes, register indexes, default grid size and bin format
// ---------------------------------------------------------------------------
`default_nettype none
package dmrd_pkg;
  localparam int GRID_X_DEF = 64;
  localparam int GRID_Y_DEF = 64;
  localparam int BIN_W = 48;
  localparam int COORD_W = 24;
  localparam int IDX_W = 12;

  localparam logic [1:0] OP_DEPOSIT = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] REG_ORG_X = 2'd0;
  localparam logic [1:0] REG_ORG_Y = 2'd1;
  localparam logic [1:0] REG_BIN_W = 2'd2;
  localparam logic [1:0] REG_BIN_H = 2'd3;

  localparam logic [BIN_W-1:0] BIN_MAX = {BIN_W{1'b1}};

  typedef struct packed {
    logic start;
    logic signed [27:0] num;
    logic [25:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic signed [27:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

[rtl/density_map_rectangle_deposit_unit.sv]
// ---------------------------------------------------------------------------
// density_map_rectangle_deposit_unit: bin density map with rectangle deposit
// sequencer around a shared floor divider and a bin ram
// ---------------------------------------------------------------------------
// channel  dir  content
// in_      in   tuser operation; tdata {bin_index, charge_ratio, rect_height,
//               rect_width, center_y, center_x}
// out_     out  tdata {saturated, bin_value}
// cfg_     in   write enable, index, 24 bit data
// read: address set in S_RDA, registered ram data taken in S_RDWAIT, then result; unused code: zero result, no work
// deposit: 4 floor divisions, then a row overlap step per bin row and, per
// touched bin, the steps overlap, multiply, scale, read, write back
// clear: zeroes every bin in address order; the same clearing pass runs after reset
// not ready while an item is in work or its result is not taken
`default_nettype none
module density_map_rectangle_deposit_unit
  import dmrd_pkg::*;
#(
  parameter int GRID_X = GRID_X_DEF,
  parameter int GRID_Y = GRID_Y_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // operation
  input  wire logic [1:0]   in_tuser,
  // center_x, center_y, rect_width, rect_height, charge_ratio, bin_index
  input  wire logic [127:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // bin_value, saturated
  output logic [55:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [23:0]  cfg_wdata
);
  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW = $clog2(DEPTH);
  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DIV, S_DWAIT, S_ROWOV, S_COLOV, S_MUL, S_INC,
    S_RD, S_WR, S_RDA, S_RDWAIT, S_CLR, S_OUT
  } state_t;
  state_t state_r;

  logic signed [23:0] org_x_r, org_y_r;
  logic [23:0] bw_r, bh_r;
  logic signed [26:0] left_r, right_r, bot_r, top_r;
  logic [15:0] ratio_r;
  logic [IDX_W-1:0] idx_r;
  logic [1:0] dsel_r;
  logic signed [27:0] bx0_r, bx1_r, by0_r, by1_r;
  logic [XW-1:0] bx_r;
  logic [YW-1:0] by_r;
  logic [26:0] oy_r, ox_r;
  logic [53:0] area_r;
  logic [BIN_W:0] inc_r;
  logic [AW-1:0] addr_r;
  logic sat_r;
  logic [BIN_W-1:0] val_r;
  logic ram_we;
  logic [BIN_W-1:0] ram_wd, ram_rd;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [24:0] bw2, bh2;
  logic signed [26:0] ox2, oy2;
  assign bw2 = {(bw_r == '0) ? 24'd1 : bw_r, 1'b0};
  assign bh2 = {(bh_r == '0) ? 24'd1 : bh_r, 1'b0};
  assign ox2 = {{2{org_x_r[23]}}, org_x_r, 1'b0};
  assign oy2 = {{2{org_y_r[23]}}, org_y_r, 1'b0};

  // shared overlap unit: one axis per cycle
  logic signed [37:0] ebase, elo, ehi, e_end, o_lo, o_hi, o_diff;
  logic [24:0] esz;
  logic [9:0] eidx;
  logic use_y;
  assign use_y = (state_r == S_ROWOV);
  always_comb begin
    esz = use_y ? bh2 : bw2;
    eidx = use_y ? 10'(by_r) : 10'(bx_r);
    ebase = 38'(use_y ? oy2 : ox2) + 38'(signed'({1'b0, eidx}) * signed'({1'b0, esz}));
    e_end = ebase + 38'(signed'({1'b0, esz}));
    elo = use_y ? 38'(bot_r) : 38'(left_r);
    ehi = use_y ? 38'(top_r) : 38'(right_r);
    o_hi = (ehi < e_end) ? ehi : e_end;
    o_lo = (elo > ebase) ? elo : ebase;
    o_diff = o_hi - o_lo;
  end

  logic [BIN_W+1:0] sum;
  logic sum_ovf;
  assign sum = {2'b0, ram_rd} + {1'b0, inc_r};
  assign sum_ovf = |sum[BIN_W+1:BIN_W];

  always_comb begin
    dreq.start = (state_r == S_DIV);
    unique case (dsel_r)
      2'd0: dreq.num = 28'(left_r) - 28'(ox2);
      2'd1: dreq.num = 28'(right_r) - 28'(ox2);
      2'd2: dreq.num = 28'(bot_r) - 28'(oy2);
      default: dreq.num = 28'(top_r) - 28'(oy2);
    endcase
    dreq.den = {1'b0, dsel_r[1] ? bh2 : bw2};
    ram_we = (state_r == S_INIT) || (state_r == S_CLR) || (state_r == S_WR);
    ram_wd = (state_r == S_WR) ? (sum_ovf ? BIN_MAX : sum[BIN_W-1:0]) : '0;
  end

  dmrd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  dmrd_ram #(.WIDTH(BIN_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(addr_r), .wdata(ram_wd), .rdata(ram_rd));

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {7'b0, sat_r, val_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      addr_r <= '0;
      org_x_r <= '0; org_y_r <= '0; bw_r <= 24'd256; bh_r <= 24'd256;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ORG_X: org_x_r <= cfg_wdata;
          REG_ORG_Y: org_y_r <= cfg_wdata;
          REG_BIN_W: bw_r <= cfg_wdata;
          REG_BIN_H: bh_r <= cfg_wdata;
        endcase
      end
      unique case (state_r)
        S_INIT, S_CLR: begin
          addr_r <= addr_r + AW'(1);
          if (addr_r == AW'(DEPTH - 1)) state_r <= (state_r == S_CLR) ? S_OUT : S_IDLE;
        end
        S_IDLE: if (in_tvalid) begin
          left_r <= {{2{in_tdata[23]}}, in_tdata[23:0], 1'b0} - {3'b0, in_tdata[71:48]};
          right_r <= {{2{in_tdata[23]}}, in_tdata[23:0], 1'b0} + {3'b0, in_tdata[71:48]};
          bot_r <= {{2{in_tdata[47]}}, in_tdata[47:24], 1'b0} - {3'b0, in_tdata[95:72]};
          top_r <= {{2{in_tdata[47]}}, in_tdata[47:24], 1'b0} + {3'b0, in_tdata[95:72]};
          ratio_r <= in_tdata[111:96];
          idx_r <= in_tdata[123:112];
          sat_r <= 1'b0;
          val_r <= '0;
          dsel_r <= 2'd0;
          unique case (in_tuser)
            OP_DEPOSIT: state_r <= S_DIV;
            OP_READ: begin
              addr_r <= AW'(in_tdata[123:112]);
              state_r <= S_RDA;
            end
            OP_CLEAR: begin
              addr_r <= '0;
              state_r <= S_CLR;
            end
            default: state_r <= S_OUT;
          endcase
        end
        S_DIV: state_r <= S_DWAIT;
        S_DWAIT: if (drsp.done) begin
          dsel_r <= dsel_r + 2'd1;
          if (dsel_r == 2'd3) begin
            // clamp ranges and test for empty
            logic signed [27:0] x0, x1, y0, y1;
            x0 = bx0_r[27] ? 28'sd0 : bx0_r;
            x1 = (bx1_r > 28'(GRID_X - 1)) ? 28'(GRID_X - 1) : bx1_r;
            y0 = by0_r[27] ? 28'sd0 : by0_r;
            y1 = (drsp.quo > 28'(GRID_Y - 1)) ? 28'(GRID_Y - 1) : drsp.quo;
            bx0_r <= x0; bx1_r <= x1; by0_r <= y0; by1_r <= y1;
            bx_r <= XW'(x0); by_r <= YW'(y0);
            state_r <= (x0 > x1 || y0 > y1) ? S_OUT : S_ROWOV;
          end else begin
            unique case (dsel_r)
              2'd0: bx0_r <= drsp.quo;
              2'd1: bx1_r <= drsp.quo;
              default: by0_r <= drsp.quo;
            endcase
            state_r <= S_DIV;
          end
        end
        S_ROWOV: begin
          oy_r <= o_diff[37] ? 27'd0 : 27'(o_diff);
          state_r <= S_COLOV;
        end
        S_COLOV: begin
          ox_r <= o_diff[37] ? 27'd0 : 27'(o_diff);
          addr_r <= AW'(by_r) * AW'(GRID_X) + AW'(bx_r);
          state_r <= S_MUL;
        end
        S_MUL: begin
          area_r <= ox_r * oy_r;
          state_r <= S_INC;
        end
        S_INC: begin
          inc_r <= (BIN_W+1)'((70'(area_r) * 70'(ratio_r)) >> 17);
          state_r <= S_RD;
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          if (sum_ovf) sat_r <= 1'b1;
          if (28'(bx_r) < bx1_r) begin
            bx_r <= bx_r + XW'(1);
            state_r <= S_COLOV;
          end else if (28'(by_r) < by1_r) begin
            bx_r <= XW'(bx0_r);
            by_r <= by_r + YW'(1);
            state_r <= S_ROWOV;
          end else state_r <= S_OUT;
        end
        S_RDA: state_r <= S_RDWAIT;
        S_RDWAIT: begin
          if (32'(idx_r) < 32'(DEPTH)) val_r <= ram_rd;
          state_r <= S_OUT;
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/dmrd_ram.sv]
// ---------------------------------------------------------------------------
// dmrd_ram: generic single port ram
// one access per cycle (a write also reads the old data), registered read data
// ---------------------------------------------------------------------------
`default_nettype none
module dmrd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[rtl/dmrd_div.sv]
// ---------------------------------------------------------------------------
// dmrd_div: floor divider
// restoring division, one quotient bit per cycle, floor rounding for negatives
// ---------------------------------------------------------------------------
`default_nettype none
module dmrd_div
  import dmrd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  localparam int NW = 28;
  logic [NW-1:0] mag_r, mag_nxt;
  logic [NW:0] rem_r, rem_nxt;
  logic [25:0] den_r;
  logic neg_r;
  logic [4:0] cnt_r;
  logic busy_r;
  logic [NW:0] trial;
  logic [NW-1:0] q;

  always_comb begin
    trial = {rem_r[NW-1:0], mag_r[NW-1]} - {3'b0, den_r};
    if (!trial[NW]) begin
      rem_nxt = trial;
      mag_nxt = {mag_r[NW-2:0], 1'b1};
    end else begin
      rem_nxt = {rem_r[NW-1:0], mag_r[NW-1]};
      mag_nxt = {mag_r[NW-2:0], 1'b0};
    end
    q = neg_r ? (~mag_r + ((rem_r != '0) ? NW'(1) : NW'(0)) + NW'(0)) : mag_r;
    if (neg_r) q = ~mag_r + NW'(1) - ((rem_r != '0) ? NW'(1) : NW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        neg_r <= req.num[NW-1];
        mag_r <= req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
        rem_r <= '0;
        den_r <= req.den;
        cnt_r <= 5'(NW);
      end else if (busy_r) begin
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          rsp.done <= 1'b1;
          rsp.quo <= q;
        end else begin
          mag_r <= mag_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/dmrd_checker.sv]
// ---------------------------------------------------------------------------
// dmrd_checker: port level checks for the deposit unit
// handshake and result sanity
// ---------------------------------------------------------------------------
`default_nettype none
module dmrd_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [55:0]  out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("out hold");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("ready after accept");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:49] == 7'd0) else $error("pad bits");
endmodule
bind density_map_rectangle_deposit_unit dmrd_checker u_chk (.*);
`default_nettype wire
